@@ sv/scm_pkg.sv @@
package scm_pkg;

    localparam int FA_W       = 14;
    localparam int VAL_W      = 16;
    localparam int OUT_W      = 32;
    localparam int ACC_W      = 36;
    localparam int CH_W       = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int DIM_W      = 5;
    localparam int CHN_W      = 4;
    localparam int CLAMP_W    = 7;

    localparam int DEF_MAX_HEIGHT = 16;
    localparam int DEF_MAX_WIDTH  = 16;
    localparam int DEF_MAX_CIN    = 8;
    localparam int DEF_MAX_COUT   = 8;

    localparam logic [DIM_W-1:0] RST_MAP_HEIGHT   = 5'd16;
    localparam logic [DIM_W-1:0] RST_MAP_WIDTH    = 5'd16;
    localparam logic [CHN_W-1:0] RST_CHANNELS_IN  = 4'd8;
    localparam logic [CHN_W-1:0] RST_CHANNELS_OUT = 4'd8;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_FEATURE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAP_HEIGHT   = 2'd0,
        REG_MAP_WIDTH    = 2'd1,
        REG_CHANNELS_IN  = 2'd2,
        REG_CHANNELS_OUT = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic issue;
        logic clear;
    } mac_ctrl_t;

    // zero acts as one, anything above the limit acts as the limit
    function automatic logic [CLAMP_W-1:0] clamp_reg(input logic [CLAMP_W-1:0] v,
                                                     input logic [CLAMP_W-1:0] maxv);
        logic [CLAMP_W-1:0] r;
        if (v == '0)
        begin
            r = CLAMP_W'(1);
        end
        else if (v > maxv)
        begin
            r = maxv;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

@@ sv/scm_ram.sv @@
module scm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/scm_cmac.sv @@
module scm_cmac #(
    parameter int MAX_COUT = scm_pkg::DEF_MAX_COUT,
    localparam int CO_W = (MAX_COUT > 1) ? $clog2(MAX_COUT) : 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  scm_pkg::mac_ctrl_t                ctrl,
    input  logic [CO_W-1:0]                   co,
    input  logic signed [scm_pkg::VAL_W-1:0]  feat_real,
    input  logic signed [scm_pkg::VAL_W-1:0]  feat_imag,
    input  logic [2*scm_pkg::VAL_W-1:0]       filter_word,
    output logic                              busy,
    output logic signed [scm_pkg::OUT_W-1:0]  sat_real,
    output logic signed [scm_pkg::OUT_W-1:0]  sat_imag,
    output logic                              sat_flag
);

    import scm_pkg::*;

    localparam int P_W = 2 * VAL_W;
    localparam int EXT_W = ACC_W - P_W;

    logic            v1_reg, v2_reg;
    logic [CO_W-1:0] co1_reg, co2_reg;
    logic signed [P_W-1:0] p_rr_reg, p_ii_reg, p_ir_reg, p_ri_reg;
    logic signed [ACC_W-1:0] acc_re_reg [MAX_COUT];
    logic signed [ACC_W-1:0] acc_im_reg [MAX_COUT];

    logic signed [VAL_W-1:0] wr, wi;
    logic [CO_W-1:0]         rd_idx;
    logic signed [ACC_W-1:0] acc_re_cur, acc_im_cur;
    logic signed [ACC_W-1:0] acc_re_next, acc_im_next;
    logic                    re_ok, im_ok;

    assign wr = filter_word[VAL_W-1:0];
    assign wi = filter_word[P_W-1:VAL_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            co1_reg <= '0;
            co2_reg <= '0;
        end
        else
        begin
            v1_reg  <= ctrl.issue;
            v2_reg  <= v1_reg;
            co1_reg <= co;
            co2_reg <= co1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            p_rr_reg <= feat_real * wr;
            p_ii_reg <= feat_imag * wi;
            p_ir_reg <= feat_imag * wr;
            p_ri_reg <= feat_real * wi;
        end
    end

    // x * conj(w): re += fr*wr + fi*wi, im += fi*wr - fr*wi
    assign rd_idx     = v2_reg ? co2_reg : co;
    assign acc_re_cur = acc_re_reg[rd_idx];
    assign acc_im_cur = acc_im_reg[rd_idx];
    assign acc_re_next = acc_re_cur + {{EXT_W{p_rr_reg[P_W-1]}}, p_rr_reg}
                                    + {{EXT_W{p_ii_reg[P_W-1]}}, p_ii_reg};
    assign acc_im_next = acc_im_cur + {{EXT_W{p_ir_reg[P_W-1]}}, p_ir_reg}
                                    - {{EXT_W{p_ri_reg[P_W-1]}}, p_ri_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_COUT; i++)
            begin
                acc_re_reg[i] <= '0;
                acc_im_reg[i] <= '0;
            end
        end
        else if (ctrl.clear)
        begin
            for (int i = 0; i < MAX_COUT; i++)
            begin
                acc_re_reg[i] <= '0;
                acc_im_reg[i] <= '0;
            end
        end
        else if (v2_reg)
        begin
            acc_re_reg[co2_reg] <= acc_re_next;
            acc_im_reg[co2_reg] <= acc_im_next;
        end
    end

    assign re_ok = (&acc_re_cur[ACC_W-1:OUT_W-1]) | ~(|acc_re_cur[ACC_W-1:OUT_W-1]);
    assign im_ok = (&acc_im_cur[ACC_W-1:OUT_W-1]) | ~(|acc_im_cur[ACC_W-1:OUT_W-1]);

    assign sat_real = re_ok ? acc_re_cur[OUT_W-1:0] :
                      (acc_re_cur[ACC_W-1] ? {1'b1, {(OUT_W-1){1'b0}}}
                                           : {1'b0, {(OUT_W-1){1'b1}}});
    assign sat_imag = im_ok ? acc_im_cur[OUT_W-1:0] :
                      (acc_im_cur[ACC_W-1] ? {1'b1, {(OUT_W-1){1'b0}}}
                                           : {1'b0, {(OUT_W-1){1'b1}}});
    assign sat_flag = ~(re_ok & im_ok);
    assign busy     = v1_reg | v2_reg;

endmodule

@@ sv/spectral_conv_complex_mac.sv @@
// Frequency-domain convolution layer: filter words are loaded into an on-chip store,
// then feature elements stream in row, column, in-channel order and each one is
// multiplied by the conjugate filter of every out channel through one shared complex
// MAC, one out channel per cycle. A load word is written in S_LOAD, after S_WRAP wraps
// its address when the store depth is not a power of two and below 2^FA_W. After a
// feature word is accepted, a shared multiply-add builds its filter base address,
// the word is issued into the MAC once per out channel and the MAC pipeline drains.
// On a pixel's last in-channel, one saturated Q16.16 result per out channel is
// emitted, held while out_ready stalls, after which the accumulators are cleared.
// The block takes no word while busy; the last result may still sit in the output
// register when the next word is accepted. The filter store needs no clearing pass.
module spectral_conv_complex_mac #(
    parameter int MAX_HEIGHT = scm_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_WIDTH  = scm_pkg::DEF_MAX_WIDTH,
    parameter int MAX_CIN    = scm_pkg::DEF_MAX_CIN,
    parameter int MAX_COUT   = scm_pkg::DEF_MAX_COUT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [scm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [scm_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              opcode,
    input  logic [scm_pkg::FA_W-1:0]          filter_address,
    input  logic signed [scm_pkg::VAL_W-1:0]  value_real,
    input  logic signed [scm_pkg::VAL_W-1:0]  value_imag,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [scm_pkg::OUT_W-1:0]  out_real,
    output logic signed [scm_pkg::OUT_W-1:0]  out_imag,
    output logic [scm_pkg::CH_W-1:0]          out_channel,
    output logic                              last_of_pixel,
    output logic                              last_of_map,
    output logic                              saturated
);

    import scm_pkg::*;

    localparam int DEPTH  = MAX_HEIGHT * MAX_WIDTH * MAX_CIN * MAX_COUT;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CI_W   = (MAX_CIN > 1) ? $clog2(MAX_CIN) : 1;
    localparam int CO_W   = (MAX_COUT > 1) ? $clog2(MAX_COUT) : 1;
    localparam int H_W    = $clog2(MAX_HEIGHT + 1);
    localparam int W_W    = $clog2(MAX_WIDTH + 1);
    localparam int CIN_W  = $clog2(MAX_CIN + 1);
    localparam int COUT_W = $clog2(MAX_COUT + 1);
    localparam int WORD_W = 2 * VAL_W;

    localparam bit NEED_WRAP = (DEPTH < (1 << FA_W)) && ((DEPTH & (DEPTH - 1)) != 0);
    localparam int DV_W   = 2 * FA_W;
    localparam logic [DV_W-1:0] DV_INIT = DV_W'(DEPTH) << (FA_W - 1);
    localparam int STEP_W = $clog2(FA_W);
    localparam logic [STEP_W-1:0] WRAP_LAST = STEP_W'(FA_W - 1);
    localparam logic [STEP_W-1:0] CALC_LAST = STEP_W'(2);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRAP,
        S_LOAD,
        S_CALC,
        S_ISSUE,
        S_DRAIN,
        S_EMIT
    } state_t;

    state_t state_reg;

    logic [DIM_W-1:0] height_cfg_reg, width_cfg_reg;
    logic [CHN_W-1:0] cin_cfg_reg, cout_cfg_reg;

    logic [ROW_W-1:0]  row_reg;
    logic [COL_W-1:0]  col_reg;
    logic [CI_W-1:0]   ci_reg;
    logic [CO_W-1:0]   co_reg;
    logic [STEP_W-1:0] step_reg;
    logic [AW-1:0]     base_reg;
    logic [FA_W-1:0]   la_reg;
    logic [DV_W-1:0]   dv_reg;
    logic [WORD_W-1:0] lw_reg;
    logic signed [VAL_W-1:0] fr_reg, fi_reg;

    logic                    out_valid_reg;
    logic signed [OUT_W-1:0] out_real_reg, out_imag_reg;
    logic [CH_W-1:0]         out_channel_reg;
    logic                    last_of_pixel_reg, last_of_map_reg, saturated_reg;

    logic [H_W-1:0]    h_c;
    logic [W_W-1:0]    w_c;
    logic [CIN_W-1:0]  cin_c;
    logic [COUT_W-1:0] cout_c;
    logic last_ci, last_col, last_row, co_last;
    logic [AW-1:0]      mul_a, add_b, calc_val;
    logic [CLAMP_W-1:0] mul_b;
    logic               in_fire, out_load;
    mac_ctrl_t          mac_ctrl;
    logic               mac_busy;
    logic [WORD_W-1:0]  filter_word;
    logic signed [OUT_W-1:0] mac_real, mac_imag;
    logic               mac_sat;

    assign h_c    = H_W'(clamp_reg(CLAMP_W'(height_cfg_reg), CLAMP_W'(MAX_HEIGHT)));
    assign w_c    = W_W'(clamp_reg(CLAMP_W'(width_cfg_reg), CLAMP_W'(MAX_WIDTH)));
    assign cin_c  = CIN_W'(clamp_reg(CLAMP_W'(cin_cfg_reg), CLAMP_W'(MAX_CIN)));
    assign cout_c = COUT_W'(clamp_reg(CLAMP_W'(cout_cfg_reg), CLAMP_W'(MAX_COUT)));

    assign last_ci  = (CIN_W'(ci_reg) + CIN_W'(1)) >= cin_c;
    assign last_col = (W_W'(col_reg) + W_W'(1)) >= w_c;
    assign last_row = (H_W'(row_reg) + H_W'(1)) >= h_c;
    assign co_last  = (COUT_W'(co_reg) + COUT_W'(1)) == cout_c;

    // base = ((row*w + col)*cin + ci)*cout, one multiply-add per step
    always_comb
    begin
        case (step_reg)
            STEP_W'(0):
            begin
                mul_a = AW'(row_reg);
                mul_b = CLAMP_W'(w_c);
                add_b = AW'(col_reg);
            end
            STEP_W'(1):
            begin
                mul_a = base_reg;
                mul_b = CLAMP_W'(cin_c);
                add_b = AW'(ci_reg);
            end
            default:
            begin
                mul_a = base_reg;
                mul_b = CLAMP_W'(cout_c);
                add_b = '0;
            end
        endcase
    end

    assign calc_val = AW'(mul_a * mul_b) + add_b;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_load = (state_reg == S_EMIT) && (!out_valid_reg || out_ready);

    assign mac_ctrl.issue = (state_reg == S_ISSUE);
    assign mac_ctrl.clear = out_load && co_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_cfg_reg <= RST_MAP_HEIGHT;
            width_cfg_reg  <= RST_MAP_WIDTH;
            cin_cfg_reg    <= RST_CHANNELS_IN;
            cout_cfg_reg   <= RST_CHANNELS_OUT;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MAP_HEIGHT:   height_cfg_reg <= cfg_data;
                REG_MAP_WIDTH:    width_cfg_reg  <= cfg_data;
                REG_CHANNELS_IN:  cin_cfg_reg    <= cfg_data[CHN_W-1:0];
                REG_CHANNELS_OUT: cout_cfg_reg   <= cfg_data[CHN_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            row_reg           <= '0;
            col_reg           <= '0;
            ci_reg            <= '0;
            co_reg            <= '0;
            step_reg          <= '0;
            base_reg          <= '0;
            la_reg            <= '0;
            dv_reg            <= '0;
            lw_reg            <= '0;
            fr_reg            <= '0;
            fi_reg            <= '0;
            out_valid_reg     <= 1'b0;
            out_real_reg      <= '0;
            out_imag_reg      <= '0;
            out_channel_reg   <= '0;
            last_of_pixel_reg <= 1'b0;
            last_of_map_reg   <= 1'b0;
            saturated_reg     <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg     <= 1'b1;
                out_real_reg      <= mac_real;
                out_imag_reg      <= mac_imag;
                out_channel_reg   <= CH_W'(co_reg);
                last_of_pixel_reg <= co_last;
                last_of_map_reg   <= last_col && last_row;
                saturated_reg     <= mac_sat;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        step_reg <= '0;
                        if (opcode == OP_LOAD)
                        begin
                            la_reg    <= filter_address;
                            lw_reg    <= {value_imag, value_real};
                            dv_reg    <= DV_INIT;
                            state_reg <= NEED_WRAP ? S_WRAP : S_LOAD;
                        end
                        else
                        begin
                            fr_reg    <= value_real;
                            fi_reg    <= value_imag;
                            state_reg <= S_CALC;
                        end
                    end
                end
                S_WRAP:
                begin
                    if ({{FA_W{1'b0}}, la_reg} >= dv_reg)
                    begin
                        la_reg <= la_reg - dv_reg[FA_W-1:0];
                    end
                    dv_reg   <= dv_reg >> 1;
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == WRAP_LAST)
                    begin
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    state_reg <= S_IDLE;
                end
                S_CALC:
                begin
                    base_reg <= calc_val;
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == CALC_LAST)
                    begin
                        co_reg    <= '0;
                        state_reg <= S_ISSUE;
                    end
                end
                S_ISSUE:
                begin
                    if (co_last)
                    begin
                        state_reg <= S_DRAIN;
                    end
                    else
                    begin
                        co_reg <= co_reg + CO_W'(1);
                    end
                end
                S_DRAIN:
                begin
                    if (!mac_busy)
                    begin
                        if (last_ci)
                        begin
                            co_reg    <= '0;
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            ci_reg    <= ci_reg + CI_W'(1);
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_EMIT:
                begin
                    if (out_load)
                    begin
                        if (co_last)
                        begin
                            ci_reg <= '0;
                            if (last_col)
                            begin
                                col_reg <= '0;
                                row_reg <= last_row ? '0 : row_reg + ROW_W'(1);
                            end
                            else
                            begin
                                col_reg <= col_reg + COL_W'(1);
                            end
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            co_reg <= co_reg + CO_W'(1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    scm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_filter_ram (
        .clk   (clk),
        .we    (state_reg == S_LOAD),
        .waddr (AW'(la_reg)),
        .wdata (lw_reg),
        .raddr (base_reg + AW'(co_reg)),
        .rdata (filter_word)
    );

    scm_cmac #(
        .MAX_COUT (MAX_COUT)
    ) u_cmac (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (mac_ctrl),
        .co          (co_reg),
        .feat_real   (fr_reg),
        .feat_imag   (fi_reg),
        .filter_word (filter_word),
        .busy        (mac_busy),
        .sat_real    (mac_real),
        .sat_imag    (mac_imag),
        .sat_flag    (mac_sat)
    );

    assign out_valid     = out_valid_reg;
    assign out_real      = out_real_reg;
    assign out_imag      = out_imag_reg;
    assign out_channel   = out_channel_reg;
    assign last_of_pixel = last_of_pixel_reg;
    assign last_of_map   = last_of_map_reg;
    assign saturated     = saturated_reg;

    a_emit_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> !mac_busy)
        else $error("emit while MAC pipeline still busy");

    a_issue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ISSUE) |-> (COUT_W'(co_reg) < cout_c))
        else $error("out channel index beyond channels_out");

    a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid_reg) |-> $past(out_ready))
        else $error("result word dropped before it was taken");

endmodule

@@ verif/spectral_conv_complex_mac_checker.sv @@
`timescale 1ns / 100ps

module spectral_conv_complex_mac_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [scm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [scm_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic                              opcode,
    input  logic [scm_pkg::FA_W-1:0]          filter_address,
    input  logic signed [scm_pkg::VAL_W-1:0]  value_real,
    input  logic signed [scm_pkg::VAL_W-1:0]  value_imag,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic signed [scm_pkg::OUT_W-1:0]  out_real,
    input  logic signed [scm_pkg::OUT_W-1:0]  out_imag,
    input  logic [scm_pkg::CH_W-1:0]          out_channel,
    input  logic                              last_of_pixel,
    input  logic                              last_of_map,
    input  logic                              saturated,
    output int                                errors,
    output int                                pending
);
    import scm_pkg::*;

    localparam int STORE_DEPTH = DEF_MAX_HEIGHT * DEF_MAX_WIDTH * DEF_MAX_CIN * DEF_MAX_COUT;

    typedef struct {
        logic signed [OUT_W-1:0] re;
        logic signed [OUT_W-1:0] im;
        logic [CH_W-1:0]         chan;
        logic                    pix_end;
        logic                    map_end;
        logic                    clipped;
    } mac_result_t;

    mac_result_t             result_q[$];
    logic [2*VAL_W-1:0]      weights [STORE_DEPTH];
    logic signed [ACC_W-1:0] acc_re [DEF_MAX_COUT];
    logic signed [ACC_W-1:0] acc_im [DEF_MAX_COUT];
    logic [DIM_W-1:0]        reg_height;
    logic [DIM_W-1:0]        reg_width;
    logic [CHN_W-1:0]        reg_cin;
    logic [CHN_W-1:0]        reg_cout;
    int                      ci_pos;
    int                      col_pos;
    int                      row_pos;

    function automatic int eff(input int v, input int lim);
        if (v == 0)
        begin
            return 1;
        end
        return (v > lim) ? lim : v;
    endfunction

    function automatic logic signed [OUT_W-1:0] clip32(input logic signed [ACC_W-1:0] a,
                                                       inout logic hit);
        longint v;
        v = a;
        if (v > 64'sd2147483647)
        begin
            hit = 1'b1;
            return 32'sh7FFFFFFF;
        end
        if (v < -64'sd2147483648)
        begin
            hit = 1'b1;
            return 32'sh80000000;
        end
        return a[OUT_W-1:0];
    endfunction

    task automatic accept_word(input logic op, input logic [FA_W-1:0] addr,
                               input logic signed [VAL_W-1:0] fr,
                               input logic signed [VAL_W-1:0] fi);
        int                      h;
        int                      w;
        int                      cin;
        int                      cout;
        int                      a;
        logic [2*VAL_W-1:0]      wt;
        logic signed [VAL_W-1:0] wr;
        logic signed [VAL_W-1:0] wi;
        logic signed [ACC_W-1:0] term_re;
        logic signed [ACC_W-1:0] term_im;
        logic                    last_ci;
        logic                    last_col;
        logic                    last_row;
        logic                    hit;
        mac_result_t             r;
        if (op == OP_LOAD)
        begin
            weights[addr] = {fi, fr};
            return;
        end
        h = eff(reg_height, DEF_MAX_HEIGHT);
        w = eff(reg_width, DEF_MAX_WIDTH);
        cin = eff(reg_cin, DEF_MAX_CIN);
        cout = eff(reg_cout, DEF_MAX_COUT);
        for (int co = 0; co < cout; co++)
        begin
            a = co + ci_pos * cout + col_pos * cout * cin + row_pos * cout * cin * w;
            wt = weights[a % STORE_DEPTH];
            wr = wt[VAL_W-1:0];
            wi = wt[2*VAL_W-1:VAL_W];
            // x * conj(w)
            term_re = fr * wr + fi * wi;
            term_im = fi * wr - fr * wi;
            acc_re[co] = acc_re[co] + term_re;
            acc_im[co] = acc_im[co] + term_im;
        end
        last_ci = (ci_pos + 1 >= cin);
        last_col = (col_pos + 1 >= w);
        last_row = (row_pos + 1 >= h);
        if (!last_ci)
        begin
            ci_pos++;
            return;
        end
        for (int co = 0; co < cout; co++)
        begin
            hit = 1'b0;
            r.re = clip32(acc_re[co], hit);
            r.im = clip32(acc_im[co], hit);
            r.chan = CH_W'(co);
            r.pix_end = (co + 1 == cout);
            r.map_end = last_col && last_row;
            r.clipped = hit;
            result_q.push_back(r);
        end
        for (int co = 0; co < DEF_MAX_COUT; co++)
        begin
            acc_re[co] = '0;
            acc_im[co] = '0;
        end
        ci_pos = 0;
        if (last_col)
        begin
            col_pos = 0;
            row_pos = last_row ? 0 : row_pos + 1;
        end
        else
        begin
            col_pos++;
        end
    endtask

    task automatic check_field(input string label, input longint want, input longint got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
        end
    endtask

    task automatic compare_result();
        mac_result_t want;
        if (result_q.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected result word: channel %0d real %0d imag %0d",
                     $time, out_channel, out_real, out_imag);
            return;
        end
        want = result_q.pop_front();
        check_field("out_real", want.re, out_real);
        check_field("out_imag", want.im, out_imag);
        check_field("out_channel", want.chan, out_channel);
        check_field("last_of_pixel", want.pix_end, last_of_pixel);
        check_field("last_of_map", want.map_end, last_of_map);
        check_field("saturated", want.clipped, saturated);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reg_height = RST_MAP_HEIGHT;
            reg_width = RST_MAP_WIDTH;
            reg_cin = RST_CHANNELS_IN;
            reg_cout = RST_CHANNELS_OUT;
            ci_pos = 0;
            col_pos = 0;
            row_pos = 0;
            for (int co = 0; co < DEF_MAX_COUT; co++)
            begin
                acc_re[co] = '0;
                acc_im[co] = '0;
            end
            result_q.delete();
            pending = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                compare_result();
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_MAP_HEIGHT:   reg_height = cfg_data;
                    REG_MAP_WIDTH:    reg_width = cfg_data;
                    REG_CHANNELS_IN:  reg_cin = cfg_data[CHN_W-1:0];
                    REG_CHANNELS_OUT: reg_cout = cfg_data[CHN_W-1:0];
                    default:          ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                accept_word(opcode, filter_address, value_real, value_imag);
            end
            pending = result_q.size();
        end
    end

endmodule

@@ verif/spectral_conv_complex_mac_test.sv @@
`timescale 1ns / 100ps

module spectral_conv_complex_mac_test;
    import scm_pkg::*;

    localparam int STORE_DEPTH = DEF_MAX_HEIGHT * DEF_MAX_WIDTH * DEF_MAX_CIN * DEF_MAX_COUT;
    localparam int SETTLE_CYCLES = 24;
    localparam int STUCK_LIMIT = 3000;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_write;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;
    logic                     in_valid;
    logic                     in_ready;
    logic                     opcode;
    logic [FA_W-1:0]          filter_address;
    logic signed [VAL_W-1:0]  value_real;
    logic signed [VAL_W-1:0]  value_imag;
    logic                     out_valid;
    logic                     out_ready;
    logic signed [OUT_W-1:0]  out_real;
    logic signed [OUT_W-1:0]  out_imag;
    logic [CH_W-1:0]          out_channel;
    logic                     last_of_pixel;
    logic                     last_of_map;
    logic                     saturated;

    int fault_count;
    int results_due;
    int features_sent;
    int loads_sent;
    int settings_done;
    int results_seen;
    int stuck_cycles;
    bit loaded [STORE_DEPTH];
    bit tx_calm;
    bit rx_calm;
    int h_eff;
    int w_eff;
    int ci_eff;
    int co_eff;
    int pos_ci;
    int pos_col;
    int pos_row;

    spectral_conv_complex_mac dut (.*);

    spectral_conv_complex_mac_checker mac_check (
        .*,
        .errors  (fault_count),
        .pending (results_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            results_seen++;
        end
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
        begin
            stuck_cycles <= 0;
        end
        else if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STUCK_LIMIT);
            $display("spectral_conv_complex_mac_test: errors");
            $finish;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // result side: per-word random stall, with calm stretches
    initial
    begin
        int stall;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                rx_calm = !rx_calm;
            end
            stall = rx_calm ? 0 : $urandom_range(0, 12);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    function automatic int clamp_dim(input int v, input int lim);
        if (v == 0)
        begin
            return 1;
        end
        return (v > lim) ? lim : v;
    endfunction

    function automatic logic [VAL_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return VAL_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic int pick_dim(input int lim, input int field_max);
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return $urandom_range(lim + 1, field_max);
            2:       return lim;
            default: return $urandom_range(1, 4);
        endcase
    endfunction

    task automatic send_word(input logic op, input logic [FA_W-1:0] addr,
                             input logic [VAL_W-1:0] re, input logic [VAL_W-1:0] im);
        int gap;
        if ($urandom_range(0, 15) == 0)
        begin
            tx_calm = !tx_calm;
        end
        gap = tx_calm ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        filter_address <= addr;
        value_real <= re;
        value_imag <= im;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic load_filter(input int addr, input logic [VAL_W-1:0] re,
                               input logic [VAL_W-1:0] im);
        send_word(OP_LOAD, FA_W'(addr), re, im);
        loaded[addr % STORE_DEPTH] = 1'b1;
        loads_sent++;
    endtask

    // loads any filter word this element will read that was never written
    task automatic feed_element(input logic [VAL_W-1:0] re, input logic [VAL_W-1:0] im);
        int slot;
        for (int co = 0; co < co_eff; co++)
        begin
            slot = (co + pos_ci * co_eff + pos_col * co_eff * ci_eff +
                    pos_row * co_eff * ci_eff * w_eff) % STORE_DEPTH;
            if (!loaded[slot])
            begin
                load_filter(slot, rand_value(), rand_value());
            end
        end
        send_word(OP_FEATURE, FA_W'($urandom_range(0, STORE_DEPTH - 1)), re, im);
        features_sent++;
        if (pos_ci + 1 < ci_eff)
        begin
            pos_ci++;
        end
        else
        begin
            pos_ci = 0;
            if (pos_col + 1 >= w_eff)
            begin
                pos_col = 0;
                pos_row = (pos_row + 1 >= h_eff) ? 0 : pos_row + 1;
            end
            else
            begin
                pos_col++;
            end
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (results_due != 0) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic apply_shape(input int h, input int w, input int cin, input int cout);
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= REG_MAP_HEIGHT;
        cfg_data <= CFG_DATA_W'(h);
        @(posedge clk);
        cfg_index <= REG_MAP_WIDTH;
        cfg_data <= CFG_DATA_W'(w);
        @(posedge clk);
        cfg_index <= REG_CHANNELS_IN;
        cfg_data <= CFG_DATA_W'(cin);
        @(posedge clk);
        cfg_index <= REG_CHANNELS_OUT;
        cfg_data <= CFG_DATA_W'(cout);
        @(posedge clk);
        cfg_write <= 1'b0;
        h_eff = clamp_dim(h & 31, DEF_MAX_HEIGHT);
        w_eff = clamp_dim(w & 31, DEF_MAX_WIDTH);
        ci_eff = clamp_dim(cin & 15, DEF_MAX_CIN);
        co_eff = clamp_dim(cout & 15, DEF_MAX_COUT);
        settings_done++;
    endtask

    initial
    begin
        int random_features;
        int burst;
        int phase;
        rst_n <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= REG_MAP_HEIGHT;
        cfg_data <= '0;
        in_valid <= 1'b0;
        opcode <= OP_LOAD;
        filter_address <= '0;
        value_real <= '0;
        value_imag <= '0;
        h_eff = DEF_MAX_HEIGHT;
        w_eff = DEF_MAX_WIDTH;
        ci_eff = DEF_MAX_CIN;
        co_eff = DEF_MAX_COUT;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // saturation of the real part, both signs, and of the imaginary part, positive
        apply_shape(1, 1, 2, 1);
        load_filter(0, 16'h8000, 16'h8000);
        load_filter(1, 16'h8000, 16'h8000);
        repeat (2) feed_element(16'h8000, 16'h8000);
        repeat (2) feed_element(16'h7FFF, 16'h8000);
        load_filter(0, 16'h7FFF, 16'h7FFF);
        load_filter(1, 16'h7FFF, 16'h7FFF);
        repeat (2) feed_element(16'h8000, 16'h8000);
        repeat (2) feed_element(16'h0000, 16'h0000);

        // out-of-range register values
        apply_shape(31, 0, 0, 15);
        repeat (3) feed_element(rand_value(), rand_value());

        // size change in the middle of a map
        apply_shape(2, 3, 3, 2);
        repeat (7) feed_element(rand_value(), rand_value());
        apply_shape(2, 1, 2, 2);
        repeat (5) feed_element(rand_value(), rand_value());

        random_features = 0;
        phase = 0;
        while (random_features < 100)
        begin
            apply_shape(pick_dim(DEF_MAX_HEIGHT, 31), pick_dim(DEF_MAX_WIDTH, 31),
                        pick_dim(DEF_MAX_CIN, 15), pick_dim(DEF_MAX_COUT, 15));
            burst = $urandom_range(6, 24);
            for (int k = 0; k < burst; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    load_filter($urandom_range(0, STORE_DEPTH - 1), rand_value(), rand_value());
                end
                feed_element(rand_value(), rand_value());
                random_features++;
                if ((phase == 1 && k == burst / 2) || $urandom_range(0, 29) == 0)
                begin
                    drain();
                end
            end
            phase++;
        end

        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        $display("%0d feature words and %0d filter loads over %0d register settings",
                 features_sent, loads_sent, settings_done);
        $display("%0d result words compared, %0d mismatches", results_seen, fault_count);
        if (fault_count == 0 && results_due == 0)
        begin
            $display("spectral_conv_complex_mac_test: clean");
        end
        else
        begin
            $display("spectral_conv_complex_mac_test: errors");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/scm_pkg.sv
sv/scm_ram.sv
sv/scm_cmac.sv
sv/spectral_conv_complex_mac.sv
verif/spectral_conv_complex_mac_checker.sv
verif/spectral_conv_complex_mac_test.sv
